FILE: rtl/iami_pkg.sv
package iami_pkg;

	localparam int RPM_POINTS_DEF = 16;
	localparam int MAP_POINTS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int VAL_W = 16;
	localparam int IDX_W = 8;

	localparam logic [VAL_W-1:0] MAX_RPM_RST = 16'd8000;
	localparam logic [VAL_W-1:0] MAX_MAP_RST = 16'd250;

	typedef enum logic {
		OP_EVAL  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic {
		REG_MAX_RPM = 1'b0,
		REG_MAX_MAP = 1'b1
	} cfg_reg_t;

	// Item details that travel alongside the axis dividers.
	typedef struct packed {
		op_t              op;
		logic             err;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} side_t;

	// Control tag that follows an evaluation through the blend pipeline.
	typedef struct packed {
		logic valid;
		logic err;
	} tag_t;

endpackage

FILE: rtl/iami_div.sv
module iami_div import iami_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int DW = VAL_W + FRAC_BITS
) (
	input  logic             clk,
	input  logic             en,
	input  logic [VAL_W-1:0] value,
	input  logic [VAL_W-1:0] step,
	output logic [DW-1:0]    quotient
);

	// Restoring division of value * 2^FRAC_BITS by step, one quotient bit per stage.
	logic [VAL_W-1:0] rem_s [DW];
	logic [DW-1:0]    quo_s [DW];
	logic [VAL_W-1:0] val_s [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [VAL_W-1:0] rem_in;
		logic [DW-1:0]    quo_in;
		logic [VAL_W-1:0] val_in;
		logic             dbit;
		logic [VAL_W:0]   trial;
		logic [VAL_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign val_in = value;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign val_in = val_s[k-1];
		end

		if (k < VAL_W) begin : g_data_bit
			assign dbit = val_in[VAL_W-1-k];
		end else begin : g_zero_bit
			assign dbit = 1'b0;
		end

		assign trial = {rem_in, dbit};
		assign diff  = trial - {1'b0, step};
		assign ge    = (trial >= {1'b0, step});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
				quo_s[k] <= {quo_in[DW-2:0], ge};
				val_s[k] <= val_in;
			end
		end
	end

	assign quotient = quo_s[DW-1];

endmodule

FILE: rtl/iami_table.sv
module iami_table import iami_pkg::*; #(
	parameter int CELLS = RPM_POINTS_DEF * MAP_POINTS_DEF,
	localparam int AW = $clog2(CELLS)
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [3:0][AW-1:0]     rd_addr,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  logic [VAL_W-1:0]       wr_data,
	output logic [3:0][VAL_W-1:0]  rd_data
);

	// Two identical copies, each with two read ports: copy A serves the lower
	// pressure row, copy B the upper one.
	logic [VAL_W-1:0] mem_a [CELLS];
	logic [VAL_W-1:0] mem_b [CELLS];
	logic [3:0][VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
		if (en) begin
			rd_data_q[0] <= mem_a[rd_addr[0]];
			rd_data_q[1] <= mem_a[rd_addr[1]];
			rd_data_q[2] <= mem_b[rd_addr[2]];
			rd_data_q[3] <= mem_b[rd_addr[3]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/iami_blend.sv
module iami_blend import iami_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  tag_t                  tag_in,
	input  logic [3:0][VAL_W-1:0] corner,
	input  logic [FRAC_BITS-1:0]  frac_rpm,
	input  logic [FRAC_BITS-1:0]  frac_map,
	output tag_t                  tag_out,
	output logic [VAL_W-1:0]      advance
);

	localparam int WW = FRAC_BITS + 2;
	localparam int AW1 = VAL_W + WW;
	localparam int BW = AW1 + WW;
	localparam int SW = BW + 2;
	localparam logic [WW-1:0] ONE = WW'(1 << FRAC_BITS);
	localparam logic signed [SW-1:0] BIAS = SW'((1 << (2 * FRAC_BITS)) - 1);

	logic [WW-1:0] wr_lo, wr_hi, wm_lo, wm_hi;

	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [AW1-1:0] a_s1 [4];
	logic [FRAC_BITS-1:0]  fm_s1;
	logic signed [BW-1:0]  b_s2 [4];
	logic signed [SW-1:0]  p0_s3, p1_s3;
	logic signed [SW-1:0]  tot_s4;
	logic signed [SW-1:0]  biased;
	logic signed [SW-1:0]  scaled;
	logic [VAL_W-1:0]      adv_s5;

	assign wr_hi = WW'(frac_rpm);
	assign wr_lo = ONE - wr_hi;
	assign wm_hi = WW'(fm_s1);
	assign wm_lo = ONE - wm_hi;

	assign biased = tot_s4 + (tot_s4[SW-1] ? BIAS : '0);
	assign scaled = biased >>> (2 * FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= signed'(corner[0]) * signed'(wr_lo);
			a_s1[1] <= signed'(corner[1]) * signed'(wr_hi);
			a_s1[2] <= signed'(corner[2]) * signed'(wr_lo);
			a_s1[3] <= signed'(corner[3]) * signed'(wr_hi);
			fm_s1   <= frac_map;

			b_s2[0] <= a_s1[0] * signed'(wm_lo);
			b_s2[1] <= a_s1[1] * signed'(wm_lo);
			b_s2[2] <= a_s1[2] * signed'(wm_hi);
			b_s2[3] <= a_s1[3] * signed'(wm_hi);

			p0_s3 <= SW'(b_s2[0]) + SW'(b_s2[1]);
			p1_s3 <= SW'(b_s2[2]) + SW'(b_s2[3]);

			tot_s4 <= p0_s3 + p1_s3;

			adv_s5 <= tag_s4.err ? '0 : scaled[VAL_W-1:0];
		end
	end

	assign tag_out = tag_s5;
	assign advance = adv_s5;

endmodule

FILE: rtl/ignition_advance_map_interpolator.sv
// Channel | Direction | tdata (low bit up)                              | tuser
// s       | in        | rpm 16, map_kpa 16, entry_index 8, entry_value 16 | op
// m       | out       | advance 16                                      | step_error
// cfg     | in        | cfg_index 0 max_rpm, 1 max_map_kpa, cfg_data 16 | -
//
// One item is taken per cycle while the skid register is empty. An evaluation passes through the
// axis dividers, one quotient bit per stage, then the address stage, the table read and the two-level
// multiply and sum into the output register. Table writes take effect at the address stage, in order.
// Reset sets the axis steps from the default maxima; table contents are undefined until written.
// When a result waits on m, one more is held in a skid register and then the pipeline holds.
module ignition_advance_map_interpolator import iami_pkg::*; #(
	parameter int RPM_POINTS = RPM_POINTS_DEF,
	parameter int MAP_POINTS = MAP_POINTS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [55:0]      s_tdata,   // rpm, map_kpa, entry_index, entry_value
	input  logic             s_tuser,   // op
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // advance
	output logic             m_tuser,   // step_error
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int DW = VAL_W + FRAC_BITS;
	localparam int CELLS = RPM_POINTS * MAP_POINTS;
	localparam int AW = $clog2(CELLS);
	localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int RXW = $clog2(RPM_POINTS);
	localparam int MXW = $clog2(MAP_POINTS);

	// Steps are found by multiplying with a rounded-up reciprocal, exact for 16-bit maxima.
	localparam int RPM_SH = VAL_W + $clog2(RPM_POINTS);
	localparam int MAP_SH = VAL_W + $clog2(MAP_POINTS);
	localparam int RPM_PW = RPM_SH + VAL_W;
	localparam int MAP_PW = MAP_SH + VAL_W;
	localparam int RPM_RCP = ((1 << RPM_SH) + RPM_POINTS - 1) / RPM_POINTS;
	localparam int MAP_RCP = ((1 << MAP_SH) + MAP_POINTS - 1) / MAP_POINTS;
	localparam logic [VAL_W-1:0] RPM_STEP_RST = VAL_W'(MAX_RPM_RST / RPM_POINTS);
	localparam logic [VAL_W-1:0] MAP_STEP_RST = VAL_W'(MAX_MAP_RST / MAP_POINTS);
	localparam logic [VAL_W-1:0] RPM_LAST = VAL_W'(RPM_POINTS - 1);
	localparam logic [VAL_W-1:0] MAP_LAST = VAL_W'(MAP_POINTS - 1);

	logic adv;

	logic [VAL_W-1:0]  rpm_step_q, map_step_q;
	logic [RPM_PW-1:0] rpm_prod;
	logic [MAP_PW-1:0] map_prod;

	logic  vld_s [DW];
	side_t side_s [DW];
	side_t side_in;

	logic [DW-1:0] rpm_quo, map_quo;

	logic [VAL_W-1:0] rq, mq, rlo16, rhi16, mlo16, mhi16;
	logic [RXW-1:0]   rlo, rhi;
	logic [MXW-1:0]   mlo, mhi;
	logic [AW-1:0]    row_lo, row_hi;
	logic [IW-1:0]    idx_ext;

	logic                 vld_s1;
	op_t                  op_s1;
	logic                 err_s1;
	logic                 wen_s1;
	logic [AW-1:0]        waddr_s1;
	logic [VAL_W-1:0]     wval_s1;
	logic [3:0][AW-1:0]   addr_s1;
	logic [FRAC_BITS-1:0] fr_s1, fm_s1;

	tag_t                 tag_s2;
	logic [FRAC_BITS-1:0] fr_s2, fm_s2;

	logic [3:0][VAL_W-1:0] cells;
	tag_t                  res_tag;
	logic [VAL_W-1:0]      res_adv;

	logic             push, out_free;
	logic             out_valid_q, out_err_q, skid_valid_q, skid_err_q;
	logic [VAL_W-1:0] out_adv_q, skid_adv_q;

	// Configuration
	assign rpm_prod = RPM_PW'(cfg_data) * RPM_PW'(RPM_RCP);
	assign map_prod = MAP_PW'(cfg_data) * MAP_PW'(MAP_RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_step_q <= RPM_STEP_RST;
			map_step_q <= MAP_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_RPM: rpm_step_q <= rpm_prod[RPM_SH +: VAL_W];
				REG_MAX_MAP: map_step_q <= map_prod[MAP_SH +: VAL_W];
			endcase
		end
	end

	// Input and divider stages
	assign adv      = !skid_valid_q;
	assign s_tready = adv;

	assign side_in.op  = op_t'(s_tuser);
	assign side_in.err = (rpm_step_q == '0) || (map_step_q == '0);
	assign side_in.idx = s_tdata[39:32];
	assign side_in.val = s_tdata[55:40];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= s_tvalid;
			for (int k = 1; k < DW; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			for (int k = 1; k < DW; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	iami_div #(.FRAC_BITS(FRAC_BITS)) u_div_rpm (
		.clk      (clk),
		.en       (adv),
		.value    (s_tdata[15:0]),
		.step     (rpm_step_q),
		.quotient (rpm_quo)
	);

	iami_div #(.FRAC_BITS(FRAC_BITS)) u_div_map (
		.clk      (clk),
		.en       (adv),
		.value    (s_tdata[31:16]),
		.step     (map_step_q),
		.quotient (map_quo)
	);

	// Cell location and clamping at the last grid point
	always_comb begin
		rq    = rpm_quo[DW-1:FRAC_BITS];
		mq    = map_quo[DW-1:FRAC_BITS];
		rlo16 = (rq > RPM_LAST) ? RPM_LAST : rq;
		rhi16 = (rq >= RPM_LAST) ? RPM_LAST : rq + 1'b1;
		mlo16 = (mq > MAP_LAST) ? MAP_LAST : mq;
		mhi16 = (mq >= MAP_LAST) ? MAP_LAST : mq + 1'b1;
		rlo   = rlo16[RXW-1:0];
		rhi   = rhi16[RXW-1:0];
		mlo   = mlo16[MXW-1:0];
		mhi   = mhi16[MXW-1:0];
		row_lo = AW'(mlo) * AW'(RPM_POINTS);
		row_hi = AW'(mhi) * AW'(RPM_POINTS);
		idx_ext = IW'(side_s[DW-1].idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			wen_s1 <= 1'b0;
			tag_s2 <= '0;
		end else if (adv) begin
			vld_s1 <= vld_s[DW-1];
			wen_s1 <= vld_s[DW-1] && (side_s[DW-1].op == OP_WRITE)
				&& (idx_ext < IW'(CELLS));
			tag_s2.valid <= vld_s1 && (op_s1 == OP_EVAL);
			tag_s2.err   <= err_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1      <= side_s[DW-1].op;
			err_s1     <= side_s[DW-1].err;
			waddr_s1   <= idx_ext[AW-1:0];
			wval_s1    <= side_s[DW-1].val;
			addr_s1[0] <= AW'(rlo) + row_lo;
			addr_s1[1] <= AW'(rhi) + row_lo;
			addr_s1[2] <= AW'(rlo) + row_hi;
			addr_s1[3] <= AW'(rhi) + row_hi;
			fr_s1      <= rpm_quo[FRAC_BITS-1:0];
			fm_s1      <= map_quo[FRAC_BITS-1:0];
			fr_s2      <= fr_s1;
			fm_s2      <= fm_s1;
		end
	end

	iami_table #(.CELLS(CELLS)) u_table (
		.clk     (clk),
		.en      (adv),
		.rd_addr (addr_s1),
		.wr_en   (adv && wen_s1),
		.wr_addr (waddr_s1),
		.wr_data (wval_s1),
		.rd_data (cells)
	);

	iami_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.tag_in   (tag_s2),
		.corner   (cells),
		.frac_rpm (fr_s2),
		.frac_map (fm_s2),
		.tag_out  (res_tag),
		.advance  (res_adv)
	);

	// Output register with skid stage
	assign push     = adv && res_tag.valid;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_adv_q <= skid_adv_q;
				out_err_q <= skid_err_q;
			end else if (push) begin
				out_adv_q <= res_adv;
				out_err_q <= res_tag.err;
			end
		end else if (push) begin
			skid_adv_q <= res_adv;
			skid_err_q <= res_tag.err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_adv_q;
	assign m_tuser  = out_err_q;

endmodule

FILE: rtl/iami_checker.sv
module iami_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// A result flagged with a zero step carries no advance.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 16'd0)
		else $error("step error result with non-zero advance");

	// The input side only stalls while a result is held on the output.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// Back-pressure reaches the input only after a refused output transfer.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed before its transfer");

endmodule

bind ignition_advance_map_interpolator iami_checker u_iami_checker (.*);
